@@ rtl/text_to_glyph_quads_top_macros.svh @@
// ----------------------------------------------------------------------------
// text_to_glyph_quads_top_macros
// Assertion macros shared by the glyph quad RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_GLYPH_QUADS_TOP_MACROS_SVH
`define TEXT_TO_GLYPH_QUADS_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define TTGQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ttgq assertion failed");

`define TTGQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ttgq assertion failed");

`else

`define TTGQ_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define TTGQ_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/ttgq_pkg.sv @@
// ----------------------------------------------------------------------------
// ttgq_pkg
// Types, codes and saturating helpers for the glyph quad generator.
// ----------------------------------------------------------------------------
package ttgq_pkg;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_START  = 2'd1;
	localparam logic [1:0] ACT_CHAR   = 2'd2;
	localparam logic [1:0] ACT_FINISH = 2'd3;

	localparam logic [15:0] CODE_TAB   = 16'd9;
	localparam logic [15:0] CODE_LF    = 16'd10;
	localparam logic [15:0] CODE_VT    = 16'd11;
	localparam logic [15:0] CODE_CR    = 16'd13;
	localparam logic [15:0] CODE_SPACE = 16'd32;

	localparam logic signed [13:0] ADV_SPACE    = 14'sd80;
	localparam logic signed [13:0] ADV_TAB      = 14'sd480;
	localparam logic signed [13:0] GLYPH_GAP    = 14'sd48;
	localparam logic signed [13:0] START_INSET  = 14'sd48;

	localparam logic [16:0] TEX_ONE   = 17'h10000;
	localparam logic [11:0] LH_RESET  = 12'd256;
	localparam logic [15:0] LC_MAX    = 16'hFFFF;
	localparam logic [2:0]  VTX_LAST  = 3'd5;
	localparam int          QUEUE_DEPTH = 2;

	typedef logic signed [19:0] pix_t;

	typedef struct packed {
		logic [16:0] left;
		logic [16:0] right;
		logic [11:0] width;
	} glyph_t;

	typedef struct packed {
		logic        is_height;
		pix_t        x0;
		pix_t        x1;
		pix_t        y0;
		pix_t        y1;
		logic [16:0] left;
		logic [16:0] right;
		logic [15:0] line_count;
	} job_t;

	typedef struct packed {
		logic use_x1;
		logic use_y1;
		logic use_right;
		logic v_bottom;
	} corner_t;

	function automatic pix_t sat_add(pix_t a, logic signed [13:0] b);
		logic signed [20:0] s;
		s = 21'(a) + 21'(b);
		if (s > 21'sd524287)
			return 20'sh7FFFF;
		else if (s < -21'sd524288)
			return 20'sh80000;
		else
			return s[19:0];
	endfunction

	// two triangles: (x0,y0) (x1,y1) (x0,y1) / (x0,y0) (x1,y0) (x1,y1)
	function automatic corner_t corner(logic [2:0] k);
		corner_t c;
		case (k)
			3'd0:    c = '{1'b0, 1'b0, 1'b0, 1'b0};
			3'd1:    c = '{1'b1, 1'b1, 1'b1, 1'b1};
			3'd2:    c = '{1'b0, 1'b1, 1'b0, 1'b1};
			3'd3:    c = '{1'b0, 1'b0, 1'b0, 1'b0};
			3'd4:    c = '{1'b1, 1'b0, 1'b1, 1'b0};
			default: c = '{1'b1, 1'b1, 1'b1, 1'b1};
		endcase
		return c;
	endfunction

endpackage

@@ rtl/text_to_glyph_quads_top.sv @@
// ----------------------------------------------------------------------------
// text_to_glyph_quads_top
// Results are registered at the output. Throughput: one item per cycle into
// the front unless a job waits on a full queue; one result per cycle out while
// out_ready is high, so a printable character yields six vertex results.
// Reset (arst_n low, async): cursor at 0, line count 1, line height 256.
// ----------------------------------------------------------------------------
module text_to_glyph_quads_top #(
	parameter int GLYPH_COUNT = 95
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [11:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [15:0]         char_code,
	input  logic [6:0]          glyph_index,
	input  logic [16:0]         glyph_left,
	input  logic [16:0]         glyph_right,
	input  logic [11:0]         glyph_width,
	input  logic signed [15:0]  origin_x,
	input  logic signed [15:0]  origin_y,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                result_kind,
	output logic signed [19:0]  vertex_x,
	output logic signed [19:0]  vertex_y,
	output logic [16:0]         tex_u,
	output logic [16:0]         tex_v,
	output logic [27:0]         text_height,
	output logic                last
);
	import ttgq_pkg::*;

	logic [11:0] line_height_q;
	logic        q_full;
	logic        q_empty;
	logic        push;
	logic        pop;
	job_t        push_job;
	job_t        head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_height_q <= LH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			line_height_q <= cfg_data;
		end
	end

	ttgq_front #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.char_code   (char_code),
		.glyph_index (glyph_index),
		.glyph_left  (glyph_left),
		.glyph_right (glyph_right),
		.glyph_width (glyph_width),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.line_height (line_height_q),
		.q_full      (q_full),
		.push        (push),
		.push_job    (push_job)
	);

	ttgq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	ttgq_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (q_empty),
		.line_height (line_height_q),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.text_height (text_height),
		.last        (last)
	);

endmodule

@@ rtl/ttgq_front.sv @@
// ----------------------------------------------------------------------------
// ttgq_front
// Accepts items, owns the glyph table and cursor state, and queues draw jobs.
// ----------------------------------------------------------------------------
`include "text_to_glyph_quads_top_macros.svh"

module ttgq_front #(
	parameter int GLYPH_COUNT = 95
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [15:0]         char_code,
	input  logic [6:0]          glyph_index,
	input  logic [16:0]         glyph_left,
	input  logic [16:0]         glyph_right,
	input  logic [11:0]         glyph_width,
	input  logic signed [15:0]  origin_x,
	input  logic signed [15:0]  origin_y,
	input  logic [11:0]         line_height,
	input  logic                q_full,
	output logic                push,
	output ttgq_pkg::job_t      push_job
);
	import ttgq_pkg::*;

	localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

	glyph_t mem [GLYPH_COUNT];

	logic [15:0] gidx_ext;
	logic [15:0] cidx;
	logic        load_ok;
	logic        printable;
	logic        accept;

	logic               valid_s1;
	logic [1:0]         action_s1;
	logic [15:0]        code_s1;
	logic               printable_s1;
	logic signed [15:0] origin_x_s1;
	logic signed [15:0] origin_y_s1;
	glyph_t             glyph_s1;

	pix_t        cursor_x_q;
	pix_t        cursor_y_q;
	pix_t        line_start_q;
	logic [15:0] line_count_q;

	logic               needs_job;
	logic               adv;
	logic signed [13:0] neg_h;
	logic signed [13:0] adv_glyph;
	pix_t               x_right;
	pix_t               y_down;

	assign gidx_ext  = {9'b0, glyph_index};
	assign cidx      = char_code - CODE_SPACE;
	assign load_ok   = gidx_ext < 16'(GLYPH_COUNT);
	assign printable = (char_code > CODE_SPACE) && (cidx < 16'(GLYPH_COUNT));
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept && action == ACT_LOAD && load_ok)
			mem[gidx_ext[IDX_W-1:0]] <= '{glyph_left, glyph_right, glyph_width};
		if (accept && action == ACT_CHAR && printable)
			glyph_s1 <= mem[cidx[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1    <= action;
			code_s1      <= char_code;
			printable_s1 <= printable;
			origin_x_s1  <= origin_x;
			origin_y_s1  <= origin_y;
		end
	end

	assign needs_job = (action_s1 == ACT_CHAR && printable_s1) || action_s1 == ACT_FINISH;
	assign adv       = valid_s1 && (!needs_job || !q_full);
	assign push      = adv && needs_job;
	assign in_ready  = !valid_s1 || adv;

	assign neg_h     = -$signed({2'b00, line_height});
	assign adv_glyph = $signed({2'b00, glyph_s1.width}) + GLYPH_GAP;
	assign x_right   = sat_add(cursor_x_q, $signed({2'b00, glyph_s1.width}));
	assign y_down    = sat_add(cursor_y_q, neg_h);

	always_comb begin
		push_job.is_height  = action_s1 == ACT_FINISH;
		push_job.x0         = cursor_x_q;
		push_job.x1         = x_right;
		push_job.y0         = cursor_y_q;
		push_job.y1         = y_down;
		push_job.left       = glyph_s1.left;
		push_job.right      = glyph_s1.right;
		push_job.line_count = line_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			line_start_q <= '0;
			line_count_q <= 16'd1;
		end else if (adv) begin
			case (action_s1)
				ACT_START: begin
					cursor_x_q   <= sat_add($signed({origin_x_s1, 4'b0000}), START_INSET);
					line_start_q <= sat_add($signed({origin_x_s1, 4'b0000}), START_INSET);
					cursor_y_q   <= $signed({origin_y_s1, 4'b0000});
					line_count_q <= 16'd1;
				end
				ACT_CHAR: begin
					if (printable_s1) begin
						cursor_x_q <= sat_add(cursor_x_q, adv_glyph);
					end else begin
						case (code_s1)
							CODE_SPACE: cursor_x_q <= sat_add(cursor_x_q, ADV_SPACE);
							CODE_TAB:   cursor_x_q <= sat_add(cursor_x_q, ADV_TAB);
							CODE_LF, CODE_CR: begin
								if (line_count_q != LC_MAX)
									line_count_q <= line_count_q + 16'd1;
								cursor_x_q <= line_start_q;
								cursor_y_q <= y_down;
							end
							CODE_VT:    cursor_y_q <= y_down;
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	`TTGQ_ASSERT_NXT(a_s1_holds, clk, arst_n, valid_s1 && !adv, valid_s1)
	`TTGQ_ASSERT_IMP(a_push_room, clk, arst_n, push, !q_full)

endmodule

@@ rtl/ttgq_queue.sv @@
// ----------------------------------------------------------------------------
// ttgq_queue
// Short job queue between the front and the vertex emitter.
// ----------------------------------------------------------------------------
`include "text_to_glyph_quads_top_macros.svh"

module ttgq_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ttgq_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output ttgq_pkg::job_t head
);
	import ttgq_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W:0]   CNT_FULL = (PTR_W + 1)'(QUEUE_DEPTH);

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = count_q == CNT_FULL;
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`TTGQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_FULL)
	`TTGQ_ASSERT_IMP(a_pop_nonempty, clk, arst_n, pop, !empty)

endmodule

@@ rtl/ttgq_back.sv @@
// ----------------------------------------------------------------------------
// ttgq_back
// Expands queued jobs into six quad vertices or one height result.
// ----------------------------------------------------------------------------
`include "text_to_glyph_quads_top_macros.svh"

module ttgq_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ttgq_pkg::job_t      head,
	input  logic                empty,
	input  logic [11:0]         line_height,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                result_kind,
	output logic signed [19:0]  vertex_x,
	output logic signed [19:0]  vertex_y,
	output logic [16:0]         tex_u,
	output logic [16:0]         tex_v,
	output logic [27:0]         text_height,
	output logic                last
);
	import ttgq_pkg::*;

	logic [2:0] cnt_q;
	logic       out_valid_q;
	logic       result_kind_q;
	pix_t       vertex_x_q;
	pix_t       vertex_y_q;
	logic [16:0] tex_u_q;
	logic [16:0] tex_v_q;
	logic [27:0] text_height_q;
	logic        last_q;

	corner_t c;
	logic    load;
	logic    is_last;

	assign c       = corner(cnt_q);
	assign load    = !empty && (!out_valid_q || out_ready);
	assign is_last = head.is_height || cnt_q == VTX_LAST;
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (!out_valid_q || out_ready)
				out_valid_q <= !empty;
			if (load)
				cnt_q <= is_last ? 3'd0 : cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_kind_q <= head.is_height;
			last_q        <= is_last;
			if (head.is_height) begin
				vertex_x_q    <= '0;
				vertex_y_q    <= '0;
				tex_u_q       <= '0;
				tex_v_q       <= '0;
				text_height_q <= 28'(head.line_count) * 28'(line_height);
			end else begin
				vertex_x_q    <= c.use_x1 ? head.x1 : head.x0;
				vertex_y_q    <= c.use_y1 ? head.y1 : head.y0;
				tex_u_q       <= c.use_right ? head.right : head.left;
				tex_v_q       <= c.v_bottom ? TEX_ONE : 17'd0;
				text_height_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = result_kind_q;
	assign vertex_x    = vertex_x_q;
	assign vertex_y    = vertex_y_q;
	assign tex_u       = tex_u_q;
	assign tex_v       = tex_v_q;
	assign text_height = text_height_q;
	assign last        = last_q;

	`TTGQ_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= VTX_LAST)
	`TTGQ_ASSERT_IMP(a_height_last, clk, arst_n, out_valid_q && result_kind_q, last_q)
	`TTGQ_ASSERT_IMP(a_mid_quad, clk, arst_n, cnt_q != 3'd0 && !empty, !head.is_height)

endmodule
